// ----- rtl/mouse_report_to_pointer_events_unit_macros.svh -----
// Assertion macros shared by the pointer event unit RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MOUSE_REPORT_TO_POINTER_EVENTS_UNIT_MACROS_SVH
`define MOUSE_REPORT_TO_POINTER_EVENTS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MRPE_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mrpe assertion failed");
`define MRPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrpe implication failed");
`define MRPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrpe next-cycle check failed");
`else
`define MRPE_ASSERT(lbl, clk, rst_n, cond)
`define MRPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MRPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/mrpe_pkg.sv -----
// Types and constants of the pointer event unit.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package mrpe_pkg;

    localparam int COORD_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [COORD_W-1:0] RESET_LIM_X = 10'd319;
    localparam logic [COORD_W-1:0] RESET_LIM_Y = 10'd239;
    localparam logic [COORD_W-1:0] COORD_LIM   = 10'd1023;
    localparam logic [SIZE_W-1:0]  SIZE_MAX    = 11'd1024;

    localparam logic TARGET_CLICK = 1'b0;
    localparam logic TARGET_PAD   = 1'b1;

    localparam logic [1:0] CODE_CLICK = 2'd0;
    localparam logic [1:0] CODE_DRAG  = 2'd1;
    localparam logic [1:0] CODE_MOVE  = 2'd2;

    // event kinds, in emission order
    localparam int KIND_COUNT = 7;
    localparam int KIND_W     = 3;
    localparam logic [KIND_W-1:0] KIND_DRAG_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE_DOWN  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE_UP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLICK_DOWN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLICK_UP   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DRAG_UP    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DRAG_DOWN  = 3'd6;

    typedef struct packed {
        logic [7:0]        button_byte;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic              cancelled;
    } report_t;

    typedef struct packed {
        logic               event_target;
        logic [1:0]         event_code;
        logic               key_up;
        logic               extra_flag;
        logic [COORD_W-1:0] pointer_x;
        logic [COORD_W-1:0] pointer_y;
        logic               button_held;
        logic               last;
    } event_t;

    typedef struct packed {
        logic [KIND_COUNT-1:0] kinds;
        logic                  held;
        logic [COORD_W-1:0]    cur_x;
        logic [COORD_W-1:0]    cur_y;
        logic [COORD_W-1:0]    press_x;
        logic [COORD_W-1:0]    press_y;
    } plan_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/mouse_report_to_pointer_events_unit.sv -----
// Top level of the pointer event unit: front end, plan queue, event sequencer.
// Depends on mrpe_pkg, mrpe_front, mrpe_fifo and mrpe_back.
`timescale 1ns / 1ps

// Turns boot-protocol mouse reports into click and pad events. A report is
// accepted in any cycle in which the plan queue (QUEUE_DEPTH entries) has room;
// the cursor, press position and drag state update at that edge. Each report
// yields zero to four events, one per cycle through a single output register
// while m_ready does not stall it; the next plan loads as the current one's
// last event leaves. Cancelled reports and reports with no movement and no
// button edge produce nothing. The user must write screen sizes through the
// cfg port (index 0 width, 1 height) only while idle; the block does not
// enforce it. cfg_ready is always high.
module mouse_report_to_pointer_events_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mrpe_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mrpe_pkg::report_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mrpe_pkg::event_t                  m_data
);

    logic                push, pop, s_accept;
    mrpe_pkg::plan_t     plan, q_head;
    mrpe_pkg::q_status_t q_status;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~q_status.full;
    assign s_accept  = s_valid & s_ready;

    mrpe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_accept  (s_accept),
        .s_data    (s_data),
        .push      (push),
        .plan      (plan)
    );

    mrpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (plan),
        .pop     (pop),
        .rd_data (q_head),
        .status  (q_status)
    );

    mrpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_head   (q_head),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- rtl/mrpe_front.sv -----
// Front end: configuration, cursor and button state, event planning.
// Depends on mrpe_pkg; feeds plans to the queue.
`timescale 1ns / 1ps
`include "mouse_report_to_pointer_events_unit_macros.svh"

module mrpe_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [mrpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mrpe_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                               s_accept,
    input  mrpe_pkg::report_t                  s_data,
    output logic                               push,
    output mrpe_pkg::plan_t                    plan
);

    logic [mrpe_pkg::COORD_W-1:0] lim_x_reg, lim_x_next;
    logic [mrpe_pkg::COORD_W-1:0] lim_y_reg, lim_y_next;
    logic [mrpe_pkg::COORD_W-1:0] cur_x_reg, cur_x_next;
    logic [mrpe_pkg::COORD_W-1:0] cur_y_reg, cur_y_next;
    logic [mrpe_pkg::COORD_W-1:0] press_x_reg, press_x_next;
    logic [mrpe_pkg::COORD_W-1:0] press_y_reg, press_y_next;
    logic                         prev_reg, prev_next;
    logic                         drag_reg, drag_next;

    logic                         pressed, moving, rise, fall, drag_start, drag_mid;
    logic [mrpe_pkg::COORD_W-1:0] step_x, step_y, new_x, new_y;

    function automatic logic [mrpe_pkg::COORD_W-1:0] limit_of(
        input logic [mrpe_pkg::SIZE_W-1:0] size);
        logic [mrpe_pkg::SIZE_W-1:0] dec;
        begin
            dec = size - 11'd1;
            if (size == '0) begin
                limit_of = '0;
            end else if (size > mrpe_pkg::SIZE_MAX) begin
                limit_of = mrpe_pkg::COORD_LIM;
            end else begin
                limit_of = dec[mrpe_pkg::COORD_W-1:0];
            end
        end
    endfunction

    // half the displacement, truncated toward zero, then clamp
    function automatic logic [mrpe_pkg::COORD_W-1:0] axis_step(
        input logic [mrpe_pkg::COORD_W-1:0] pos,
        input logic [7:0]                   delta,
        input logic [mrpe_pkg::COORD_W-1:0] lim);
        logic [8:0]  sum9;
        logic [8:0]  half;
        logic [11:0] p;
        begin
            sum9 = {delta[7], delta} + {8'b0, delta[7]};
            half = {sum9[8], sum9[8:1]};
            p    = {2'b00, pos} + {{3{half[8]}}, half};
            if (p[11]) begin
                axis_step = '0;
            end else if (p[10:0] > {1'b0, lim}) begin
                axis_step = lim;
            end else begin
                axis_step = p[mrpe_pkg::COORD_W-1:0];
            end
        end
    endfunction

    always_comb begin
        lim_x_next = lim_x_reg;
        lim_y_next = lim_y_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                mrpe_pkg::CFG_SCREEN_WIDTH:  lim_x_next = limit_of(cfg_data);
                mrpe_pkg::CFG_SCREEN_HEIGHT: lim_y_next = limit_of(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        pressed    = |s_data.button_byte;
        moving     = (|s_data.move_x) | (|s_data.move_y);
        rise       = pressed & ~prev_reg;
        fall       = ~pressed & prev_reg;
        step_x     = axis_step(cur_x_reg, s_data.move_x, lim_x_reg);
        step_y     = axis_step(cur_y_reg, s_data.move_y, lim_y_reg);
        new_x      = moving ? step_x : cur_x_reg;
        new_y      = moving ? step_y : cur_y_reg;
        drag_start = moving & pressed & ~drag_reg;
        drag_mid   = drag_reg | drag_start;

        plan.kinds = '0;
        plan.kinds[mrpe_pkg::KIND_DRAG_START] = drag_start;
        plan.kinds[mrpe_pkg::KIND_MOVE_DOWN]  = moving;
        plan.kinds[mrpe_pkg::KIND_MOVE_UP]    = moving;
        plan.kinds[mrpe_pkg::KIND_CLICK_DOWN] = fall & ~drag_mid;
        plan.kinds[mrpe_pkg::KIND_CLICK_UP]   = fall & ~drag_mid;
        plan.kinds[mrpe_pkg::KIND_DRAG_UP]    = fall & drag_mid;
        plan.kinds[mrpe_pkg::KIND_DRAG_DOWN]  = fall & drag_mid;
        plan.held    = pressed;
        plan.cur_x   = new_x;
        plan.cur_y   = new_y;
        plan.press_x = press_x_reg;
        plan.press_y = press_y_reg;

        push = s_accept & ~s_data.cancelled & (|plan.kinds);

        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        press_x_next = press_x_reg;
        press_y_next = press_y_reg;
        prev_next    = prev_reg;
        drag_next    = drag_reg;
        if (s_accept && !s_data.cancelled) begin
            cur_x_next = new_x;
            cur_y_next = new_y;
            if (rise) begin
                press_x_next = new_x;
                press_y_next = new_y;
            end
            prev_next = pressed;
            drag_next = drag_mid & ~fall;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_x_reg   <= mrpe_pkg::RESET_LIM_X;
            lim_y_reg   <= mrpe_pkg::RESET_LIM_Y;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            press_x_reg <= '0;
            press_y_reg <= '0;
            prev_reg    <= 1'b0;
            drag_reg    <= 1'b0;
        end else begin
            lim_x_reg   <= lim_x_next;
            lim_y_reg   <= lim_y_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            press_x_reg <= press_x_next;
            press_y_reg <= press_y_next;
            prev_reg    <= prev_next;
            drag_reg    <= drag_next;
        end
    end

    `MRPE_ASSERT_IMP(a_drag_needs_press, aclk, aresetn, drag_reg, prev_reg)

endmodule

// ----- rtl/mrpe_fifo.sv -----
// Short plan queue between the front end and the event sequencer.
// Depends on mrpe_pkg for the plan type.
`timescale 1ns / 1ps
`include "mouse_report_to_pointer_events_unit_macros.svh"

module mrpe_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mrpe_pkg::plan_t      wr_data,
    input  logic                 pop,
    output mrpe_pkg::plan_t      rd_data,
    output mrpe_pkg::q_status_t  status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mrpe_pkg::plan_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        status.full  = (count_reg == CNT_FULL);
        status.empty = (count_reg == '0);
        rd_data      = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MRPE_ASSERT(a_no_overflow, aclk, aresetn, !(push && status.full && !pop))
    `MRPE_ASSERT(a_no_underflow, aclk, aresetn, !(pop && status.empty))

endmodule

// ----- rtl/mrpe_back.sv -----
// Event sequencer: expands each queued plan into pointer events.
// Depends on mrpe_pkg; drains the plan queue, drives the result channel.
`timescale 1ns / 1ps
`include "mouse_report_to_pointer_events_unit_macros.svh"

module mrpe_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mrpe_pkg::q_status_t  q_status,
    input  mrpe_pkg::plan_t      q_head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mrpe_pkg::event_t     m_data
);

    mrpe_pkg::plan_t          work_reg, work_next;
    logic                     m_valid_reg, m_valid_next;
    mrpe_pkg::event_t         m_data_reg, m_data_next;

    logic                          busy, out_free, emit;
    logic [mrpe_pkg::KIND_COUNT-1:0] lowest, rest;
    logic [mrpe_pkg::KIND_W-1:0]     kind;
    mrpe_pkg::event_t              ev;

    always_comb begin
        busy     = |work_reg.kinds;
        out_free = ~m_valid_reg | m_ready;
        emit     = busy & out_free;
        lowest   = work_reg.kinds & (~work_reg.kinds + 1'b1);
        rest     = work_reg.kinds & ~lowest;

        kind = '0;
        for (int i = mrpe_pkg::KIND_COUNT - 1; i >= 0; i--) begin
            if (work_reg.kinds[i]) begin
                kind = mrpe_pkg::KIND_W'(i);
            end
        end

        ev.event_target = mrpe_pkg::TARGET_CLICK;
        ev.event_code   = mrpe_pkg::CODE_CLICK;
        ev.key_up       = 1'b0;
        ev.extra_flag   = 1'b1;
        ev.pointer_x    = work_reg.cur_x;
        ev.pointer_y    = work_reg.cur_y;
        ev.button_held  = 1'b1;
        ev.last         = ~(|rest);
        unique case (kind)
            mrpe_pkg::KIND_DRAG_START: begin
                ev.event_code = mrpe_pkg::CODE_DRAG;
                ev.pointer_x  = work_reg.press_x;
                ev.pointer_y  = work_reg.press_y;
            end
            mrpe_pkg::KIND_MOVE_DOWN: begin
                ev.event_target = mrpe_pkg::TARGET_PAD;
                ev.event_code   = mrpe_pkg::CODE_MOVE;
                ev.extra_flag   = 1'b0;
                ev.button_held  = work_reg.held;
            end
            mrpe_pkg::KIND_MOVE_UP: begin
                ev.event_target = mrpe_pkg::TARGET_PAD;
                ev.event_code   = mrpe_pkg::CODE_MOVE;
                ev.key_up       = 1'b1;
                ev.button_held  = work_reg.held;
            end
            mrpe_pkg::KIND_CLICK_DOWN: ;
            mrpe_pkg::KIND_CLICK_UP: begin
                ev.key_up = 1'b1;
            end
            mrpe_pkg::KIND_DRAG_UP: begin
                ev.event_code = mrpe_pkg::CODE_DRAG;
                ev.key_up     = 1'b1;
            end
            mrpe_pkg::KIND_DRAG_DOWN: begin
                ev.event_code = mrpe_pkg::CODE_DRAG;
            end
            default: ;
        endcase

        pop = ~q_status.empty & (~busy | (emit & ~(|rest)));

        work_next = work_reg;
        if (emit) begin
            work_next.kinds = rest;
        end
        if (pop) begin
            work_next = q_head;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = ev;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            work_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            work_reg    <= work_next;
        end
    end

    `MRPE_ASSERT_NXT(a_idle_loads, aclk, aresetn, !busy && !q_status.empty, busy)
    `MRPE_ASSERT_IMP(a_emit_fills_out, aclk, aresetn, emit, out_free && busy)

endmodule
